// ===== rtl/dfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types, register codes and helpers for the delimiter field splitter.
// ----------------------------------------------------------------------------
package dfs_pkg;

    // Default number of separator cells in the window
    localparam int DFS_MAX_SEP_BYTES = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_LEN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_BYTES    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_FIELDS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FIELDS   = 2'd3;

    // Register reset values
    localparam logic [3:0]  SEP_LEN_RST      = 4'd1;
    localparam logic [63:0] SEP_BYTES_RST    = 64'd44;
    localparam logic [15:0] LIMIT_FIELDS_RST = 16'hFFFF;
    localparam logic [3:0]  MIN_FIELDS_RST   = 4'd0;

    // Input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_string;
    } item_t;

    // Result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_byte_valid;
        logic        field_end;
        logic [15:0] field_index;
        logic        last_result;
    } result_t;

    // Configuration write
    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [63:0]          wr_data;
    } cfg_t;

    // Control for one window cell
    typedef struct packed {
        logic shift;   // take the neighbor's byte
        logic keep;    // cell lies inside the active window
        logic drop;    // cell is emptied by the end-of-string flush
        logic clear;   // empty the cell
    } cell_ctl_t;

    // Separator byte j; positions past the eighth compare against zero
    function automatic logic [7:0] sep_byte_at(input logic [63:0] sep, input int j);
        logic [7:0] b;
        b = 8'h00;
        if (j >= 0 && j < 8)
        begin
            b = sep[j*8 +: 8];
        end
        return b;
    endfunction

endpackage

// ===== rtl/dfs_chan_if.sv =====
// ----------------------------------------------------------------------------
// dfs_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface dfs_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/dfs_cell.sv =====
// ----------------------------------------------------------------------------
// dfs_cell
// One window cell: holds a byte and an occupied flag, passes them on to the
// next cell on a shift, and compares its byte with a separator byte.
// ----------------------------------------------------------------------------
module dfs_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  dfs_pkg::cell_ctl_t ctl,
    input  logic [7:0]        prev_byte,
    input  logic              prev_full,
    input  logic [7:0]        cmp_byte,
    input  logic              cmp_en,
    output logic [7:0]        cell_byte,
    output logic              cell_full,
    output logic              cell_eq
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       full_reg;
    logic       full_next;

    // Occupied flag: clear wins, then shift, then flush drop
    always_comb
    begin
        full_next = full_reg;
        byte_next = byte_reg;
        if (ctl.clear)
        begin
            full_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            full_next = prev_full && ctl.keep;
            byte_next = prev_byte;
        end
        else if (ctl.drop)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // Byte storage, no reset needed
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;
    assign cell_full = full_reg;
    // Cells outside the compared span do not veto a match
    assign cell_eq   = !cmp_en || (byte_reg == cmp_byte);

endmodule

// ===== rtl/dfs_result_fifo.sv =====
// ----------------------------------------------------------------------------
// dfs_result_fifo
// Two-entry output buffer: an output register plus a skid register, so the
// producer keeps going while a result waits to be taken.
// ----------------------------------------------------------------------------
module dfs_result_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dfs_pkg::result_t   push_data,
    output logic               room,
    dfs_chan_if.source         result
);

    dfs_pkg::result_t out_reg;
    dfs_pkg::result_t out_next;
    dfs_pkg::result_t skid_reg;
    dfs_pkg::result_t skid_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic             load_out;

    assign load_out = !out_valid_reg || result.ready;

    // Refill the output register from skid first, then from the producer
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (load_out)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = push_data;
                skid_valid_next = push;
            end
            else
            begin
                out_next       = push_data;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign room           = !skid_valid_reg;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

endmodule

// ===== rtl/delimiter_field_splitter.sv =====
// ----------------------------------------------------------------------------
// delimiter_field_splitter
// Splits a byte stream into fields at a configurable separator and tags each
// byte with its field index; a row of window cells holds the bytes that may
// still begin a separator.
//
//   channel  | dir | payload                                     | transaction
//   ---------+-----+---------------------------------------------+-------------
//   cfg      | in  | reg_index, wr_data                          | valid & ready
//   item     | in  | data_byte, byte_valid, end_of_string        | valid & ready
//   result   | out | out_byte, out_byte_valid, field_end,        | valid & ready
//            |     | field_index, last_result                    |
//
// A byte item is taken every cycle while item.ready is high; its result (if
// any) is registered in a two-entry output buffer.
// An end-of-string item may start the flush/pad sequencer, which emits the held
// bytes oldest first, closes the last field and pads, one result a cycle with room.
// Reset is asynchronous; no clearing pass is needed after it.
// item.ready drops while the sequencer runs or the output buffer is full.
// ----------------------------------------------------------------------------
module delimiter_field_splitter #(
    parameter int MAX_SEP_BYTES = dfs_pkg::DFS_MAX_SEP_BYTES
) (
    input  logic       clk,
    input  logic       rst_n,
    dfs_chan_if.sink   cfg,
    dfs_chan_if.sink   item,
    dfs_chan_if.source result
);

    localparam int NC  = MAX_SEP_BYTES;
    localparam int LW  = $clog2(MAX_SEP_BYTES + 1);
    localparam int CIW = (NC > 1) ? $clog2(NC) : 1;

    // Sequencer phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_FLUSH = 2'd1;
    localparam logic [1:0] PH_PAD   = 2'd2;

    // Configuration registers
    logic [3:0]  sep_len_reg;
    logic [63:0] sep_bytes_reg;
    logic [15:0] limit_reg;
    logic [3:0]  min_reg;

    // Control state
    logic [1:0]    phase_reg, phase_next;
    logic          busy_reg, busy_next;
    logic [LW-1:0] run_len_reg, run_len_next;
    logic [15:0]   fc_reg, fc_next;
    logic [3:0]    pad_reg, pad_next;

    // Window cells
    logic [7:0]         cell_byte [NC];
    logic [7:0]         prev_byte [NC];
    logic [7:0]         cmp_byte  [NC];
    logic [NC-1:0]      prev_full;
    logic [NC-1:0]      cell_full;
    logic [NC-1:0]      cell_eq;
    logic [NC-1:0]      cmp_en;
    dfs_pkg::cell_ctl_t ctl [NC];
    logic               shift_en;
    logic               clear_en;
    logic               drop_en;
    logic [CIW-1:0]     top_idx;
    logic               any_full;

    // Datapath helpers
    logic [LW-1:0]    sat_len, eff_len, len_m2;
    logic             item_acc;
    logic [7:0]       data;
    logic             byte_ok;
    logic             full_cond;
    logic             win_match;
    logic             fc_lt_limit;
    logic [15:0]      fc_inc;
    logic             bump;
    logic [15:0]      fc_after;
    logic             close_needed;
    logic [16:0]      produced0;
    logic             pad_needed;
    logic [16:0]      fc_p1;
    logic             pad_after_close;
    logic             pad_more;
    logic [7:0]       oldest;

    // Output buffer
    logic             push;
    logic             room;
    dfs_pkg::result_t push_data;

    // Configuration port
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_len_reg   <= dfs_pkg::SEP_LEN_RST;
            sep_bytes_reg <= dfs_pkg::SEP_BYTES_RST;
            limit_reg     <= dfs_pkg::LIMIT_FIELDS_RST;
            min_reg       <= dfs_pkg::MIN_FIELDS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.reg_index)
                dfs_pkg::CFG_SEP_LEN:      sep_len_reg   <= cfg.payload.wr_data[3:0];
                dfs_pkg::CFG_SEP_BYTES:    sep_bytes_reg <= cfg.payload.wr_data;
                dfs_pkg::CFG_LIMIT_FIELDS: limit_reg     <= cfg.payload.wr_data[15:0];
                dfs_pkg::CFG_MIN_FIELDS:   min_reg       <= cfg.payload.wr_data[3:0];
                default: ;
            endcase
        end
    end

    // Separator length in force: latched at string start
    assign sat_len = (int'(sep_len_reg) > MAX_SEP_BYTES) ? LW'(MAX_SEP_BYTES)
                                                         : LW'(sep_len_reg);
    assign eff_len = busy_reg ? run_len_reg : sat_len;
    assign len_m2  = eff_len - LW'(2);

    assign item.ready = (phase_reg == PH_IDLE) && room;
    assign item_acc   = item.valid && item.ready;
    assign data       = item.payload.data_byte;

    // Cell chain: newest byte enters cell 0, cell k is k+1 bytes back
    for (genvar k = 0; k < NC; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            assign prev_byte[k] = data;
            assign prev_full[k] = 1'b1;
        end
        else
        begin : g_body
            assign prev_byte[k] = cell_byte[k-1];
            assign prev_full[k] = cell_full[k-1];
        end

        // Cell k holds separator position eff_len-2-k when the window is full
        assign cmp_en[k]   = int'(eff_len) >= k + 2;
        assign cmp_byte[k] = dfs_pkg::sep_byte_at(sep_bytes_reg, int'(eff_len) - 2 - k);

        assign ctl[k].shift = shift_en;
        assign ctl[k].keep  = int'(eff_len) > k + 1;
        assign ctl[k].drop  = drop_en && (top_idx == CIW'(k));
        assign ctl[k].clear = clear_en;

        dfs_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl[k]),
            .prev_byte (prev_byte[k]),
            .prev_full (prev_full[k]),
            .cmp_byte  (cmp_byte[k]),
            .cmp_en    (cmp_en[k]),
            .cell_byte (cell_byte[k]),
            .cell_full (cell_full[k]),
            .cell_eq   (cell_eq[k])
        );
    end

    // Oldest held byte for the flush
    always_comb
    begin
        top_idx = '0;
        for (int k = 0; k < NC; k++)
        begin
            if (cell_full[k])
            begin
                top_idx = CIW'(k);
            end
        end
    end
    assign any_full = |cell_full;

    // Window decision for an incoming byte
    assign full_cond   = (eff_len == LW'(1)) || cell_full[len_m2[CIW-1:0]];
    assign win_match   = (&cell_eq) &&
                         (data == dfs_pkg::sep_byte_at(sep_bytes_reg, int'(eff_len) - 1));
    assign oldest      = (eff_len == LW'(1)) ? data : cell_byte[len_m2[CIW-1:0]];
    assign fc_lt_limit = ({1'b0, fc_reg} + 17'd1) < {1'b0, limit_reg};
    assign fc_inc      = (fc_reg == 16'hFFFF) ? fc_reg : fc_reg + 16'd1;
    assign byte_ok     = item.payload.byte_valid && (limit_reg != 16'd0);
    assign bump        = byte_ok && ((eff_len == '0) ||
                                     (full_cond && win_match && fc_lt_limit));
    assign fc_after    = bump ? fc_inc : fc_reg;

    // End-of-string bookkeeping
    assign close_needed = (limit_reg != 16'd0) && (eff_len != '0);
    assign produced0    = close_needed ? ({1'b0, fc_after} + 17'd1) :
                          (limit_reg != 16'd0) ? {1'b0, fc_after} : 17'd0;
    assign pad_needed      = produced0 < {13'd0, min_reg};
    assign fc_p1           = {1'b0, fc_reg} + 17'd1;
    assign pad_after_close = fc_p1 < {13'd0, min_reg};
    assign pad_more        = ({1'b0, pad_reg} + 5'd1) < {1'b0, min_reg};

    // Main control and result generation
    always_comb
    begin
        shift_en     = 1'b0;
        clear_en     = 1'b0;
        drop_en      = 1'b0;
        push         = 1'b0;
        push_data    = '0;
        busy_next    = busy_reg;
        run_len_next = run_len_reg;
        fc_next      = fc_reg;
        phase_next   = phase_reg;
        pad_next     = pad_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item_acc && (item.payload.byte_valid || item.payload.end_of_string))
                begin
                    if (!busy_reg)
                    begin
                        busy_next    = 1'b1;
                        run_len_next = sat_len;
                    end
                    fc_next = fc_after;

                    // Byte part
                    if (byte_ok)
                    begin
                        if (eff_len == '0)
                        begin
                            push                     = 1'b1;
                            push_data.out_byte       = data;
                            push_data.out_byte_valid = 1'b1;
                            push_data.field_end      = 1'b1;
                            push_data.field_index    = fc_reg;
                        end
                        else if (!full_cond)
                        begin
                            shift_en = 1'b1;
                        end
                        else if (win_match && fc_lt_limit)
                        begin
                            push                  = 1'b1;
                            push_data.field_end   = 1'b1;
                            push_data.field_index = fc_reg;
                            clear_en              = 1'b1;
                        end
                        else
                        begin
                            push                     = 1'b1;
                            push_data.out_byte       = oldest;
                            push_data.out_byte_valid = 1'b1;
                            push_data.field_index    = fc_reg;
                            shift_en                 = 1'b1;
                        end
                    end

                    // End part
                    if (item.payload.end_of_string)
                    begin
                        if (close_needed)
                        begin
                            phase_next = PH_FLUSH;
                        end
                        else if (pad_needed)
                        begin
                            phase_next = PH_PAD;
                            pad_next   = produced0[3:0];
                        end
                        else
                        begin
                            push_data.last_result = 1'b1;
                            busy_next             = 1'b0;
                            fc_next               = '0;
                            clear_en              = 1'b1;
                        end
                    end
                end
            end

            PH_FLUSH:
            begin
                if (room)
                begin
                    push                  = 1'b1;
                    push_data.field_index = fc_reg;
                    if (any_full)
                    begin
                        push_data.out_byte       = cell_byte[top_idx];
                        push_data.out_byte_valid = 1'b1;
                        drop_en                  = 1'b1;
                    end
                    else
                    begin
                        // Close the last field
                        push_data.field_end   = 1'b1;
                        push_data.last_result = !pad_after_close;
                        if (pad_after_close)
                        begin
                            phase_next = PH_PAD;
                            pad_next   = fc_p1[3:0];
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            busy_next  = 1'b0;
                            fc_next    = '0;
                            clear_en   = 1'b1;
                        end
                    end
                end
            end

            PH_PAD:
            begin
                if (room)
                begin
                    push                  = 1'b1;
                    push_data.field_end   = 1'b1;
                    push_data.field_index = {12'd0, pad_reg};
                    push_data.last_result = !pad_more;
                    pad_next              = pad_reg + 4'd1;
                    if (!pad_more)
                    begin
                        phase_next = PH_IDLE;
                        busy_next  = 1'b0;
                        fc_next    = '0;
                        clear_en   = 1'b1;
                    end
                end
            end

            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            busy_reg    <= 1'b0;
            run_len_reg <= '0;
            fc_reg      <= '0;
            pad_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            busy_reg    <= busy_next;
            run_len_reg <= run_len_next;
            fc_reg      <= fc_next;
            pad_reg     <= pad_next;
        end
    end

    // Output buffer
    dfs_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .room      (room),
        .result    (result)
    );

endmodule
